// File: hw/rtl/drcp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and field helpers for the depth ROI centroid projector.
package drcp_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int COORD_W    = 12;
    localparam int DEPTH_W    = 16;
    localparam int MEAN_W     = 21;
    localparam int COUNT_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int QUEUE_DEPTH = 4;

    // back-projected point and colour-frame point, both mm Q.8
    localparam int P_W = 40;
    localparam int C_W = 46;

    localparam int MEAN_OFF_X = 40;
    localparam int MEAN_OFF_Z = -20;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_INTR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_INTR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROI        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DLIMIT     = 3'd7;

    localparam logic [DEPTH_W-1:0] DLIMIT_RST = 16'd20000;

    typedef struct packed {
        logic [15:0]      fx_d;
        logic [15:0]      fy_d;
        logic [15:0]      cx_d;
        logic [15:0]      cy_d;
        logic [15:0]      fx_c;
        logic [15:0]      fy_c;
        logic [15:0]      cx_c;
        logic [15:0]      cy_c;
        logic [2:0][62:0] rot;
        logic [62:0]      trans;
        logic [15:0]      roi_x;
        logic [15:0]      roi_y;
        logic [15:0]      roi_w;
        logic [15:0]      roi_h;
        logic [15:0]      dlimit;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic [DEPTH_W-1:0] depth;
        logic               last;
        logic               keep;
    } t_pix;

    function automatic logic signed [20:0] field21(input logic [62:0] w, input logic [1:0] k);
        logic signed [20:0] f;
        case (k)
            2'd0:    f = w[20:0];
            2'd1:    f = w[41:21];
            default: f = w[62:42];
        endcase
        return f;
    endfunction

endpackage

// File: hw/rtl/drcp_cfg.sv
`timescale 1ns / 1ps
// Configuration register file.
module drcp_cfg import drcp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_cfg.dlimit <= DLIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEPTH_INTR: {r_cfg.cy_d, r_cfg.cx_d, r_cfg.fy_d, r_cfg.fx_d} <= i_cfg_data;
                REG_COLOR_INTR: {r_cfg.cy_c, r_cfg.cx_c, r_cfg.fy_c, r_cfg.fx_c} <= i_cfg_data;
                REG_ROT_X:      r_cfg.rot[0] <= i_cfg_data[62:0];
                REG_ROT_Y:      r_cfg.rot[1] <= i_cfg_data[62:0];
                REG_ROT_Z:      r_cfg.rot[2] <= i_cfg_data[62:0];
                REG_TRANS:      r_cfg.trans  <= i_cfg_data[62:0];
                REG_ROI:        {r_cfg.roi_h, r_cfg.roi_w, r_cfg.roi_y, r_cfg.roi_x} <= i_cfg_data;
                REG_DLIMIT:     r_cfg.dlimit <= i_cfg_data[15:0];
            endcase
        end
    end

endmodule

// File: hw/rtl/drcp_front.sv
`timescale 1ns / 1ps
// Front end: takes pixel words, screens them and queues them for the back end.
module drcp_front import drcp_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_column,
    input  logic [COORD_W-1:0] i_row,
    input  logic [DEPTH_W-1:0] i_depth_mm,
    input  logic               i_last_pixel,
    output logic               o_q_valid,
    output t_pix               o_q_item,
    input  logic               i_q_pop
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);

    t_pix              r_q [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr;
    logic [QA_W-1:0]   r_rd;
    logic [QA_W:0]     r_fill;
    logic              push;
    logic              pop;
    t_pix              pix;

    assign o_in_ready = (r_fill != (QA_W+1)'(QUEUE_DEPTH));
    assign o_q_valid  = (r_fill != '0);
    assign o_q_item   = r_q[r_rd];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        pix.u     = i_column;
        pix.v     = i_row;
        pix.depth = i_depth_mm;
        pix.last  = i_last_pixel;
        pix.keep  = (i_depth_mm != '0) && (i_depth_mm < i_cfg.dlimit)
                 && (i_cfg.fx_d != '0) && (i_cfg.fy_d != '0)
                 && (32'(i_column) < 32'(MAX_WIDTH)) && (32'(i_row) < 32'(MAX_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QA_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QA_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (QA_W+1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (QA_W+1)'(1);
            end
        end
    end

endmodule

// File: hw/rtl/drcp_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, signed dividend, floor quotient, one bit a cycle.
module drcp_div #(
    parameter int NW = 64,
    parameter int DW = 46
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quot
);

    localparam int K_W = $clog2(NW);

    logic            r_busy;
    logic            r_done;
    logic            r_neg;
    logic [NW-1:0]   r_mag;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [K_W-1:0]  r_k;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            q_bit;
    logic [NW-1:0]   q_adj;

    assign rem_sh  = {r_rem, r_mag[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = !rem_sub[DW];
    assign q_adj   = r_mag + NW'(r_rem != '0);
    assign o_done  = r_done;
    assign o_quot  = r_neg ? -$signed(q_adj) : $signed(r_mag);

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_neg <= i_num[NW-1];
            r_mag <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_rem <= '0;
            r_den <= i_den;
            r_k   <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[NW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_k   <= r_k + K_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == K_W'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/drcp_back.sv
`timescale 1ns / 1ps
// Back end: projection sequencer, ROI test, accumulation and frame mean.
module drcp_back import drcp_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_q_valid,
    input  t_pix                     i_q_item,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [MEAN_W-1:0] o_mean_x_mm,
    output logic signed [MEAN_W-1:0] o_mean_y_mm,
    output logic signed [MEAN_W-1:0] o_mean_z_mm,
    output logic [COUNT_W-1:0]       o_point_count,
    output logic                     o_found
);

    localparam longint HIT_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int CNT_W = $clog2(HIT_MAX + 1);
    localparam int SUM_W = CNT_W + MEAN_W;
    localparam int NW    = (SUM_W + 2 > 64) ? SUM_W + 2 : 64;
    localparam int DW    = (CNT_W + 1 > C_W) ? CNT_W + 1 : C_W;
    localparam int MA_W  = 22;
    localparam int MB_W  = 47;
    localparam logic signed [NW-1:0] P_LIM  = NW'((64'sd1 <<< (P_W - 1)) - 64'sd1);
    localparam logic signed [NW-1:0] M_MAX  = NW'((64'sd1 <<< (MEAN_W - 1)) - 64'sd1);
    localparam logic signed [C_W-1:0] MM_MAX = C_W'((64'sd1 <<< (MEAN_W - 1)) - 64'sd1);

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_PX   = 15'h0002,
        S_PY   = 15'h0004,
        S_DX   = 15'h0008,
        S_DY   = 15'h0010,
        S_RMUL = 15'h0020,
        S_RACC = 15'h0040,
        S_PU   = 15'h0080,
        S_PV   = 15'h0100,
        S_DU   = 15'h0200,
        S_DV   = 15'h0400,
        S_ROI  = 15'h0800,
        S_MEAN = 15'h1000,
        S_MDIV = 15'h2000,
        S_OUT  = 15'h4000
    } t_state;

    function automatic logic signed [P_W-1:0] sat_p(input logic signed [NW-1:0] q);
        logic signed [P_W-1:0] r;
        if (q > P_LIM) begin
            r = P_W'(P_LIM);
        end else if (q < -P_LIM) begin
            r = P_W'(-P_LIM);
        end else begin
            r = P_W'(q);
        end
        return r;
    endfunction

    function automatic logic signed [MEAN_W-1:0] sat_m(input logic signed [NW-1:0] q);
        logic signed [MEAN_W-1:0] r;
        if (q > M_MAX) begin
            r = MEAN_W'(M_MAX);
        end else if (q < -M_MAX - NW'(1)) begin
            r = MEAN_W'(-M_MAX - NW'(1));
        end else begin
            r = MEAN_W'(q);
        end
        return r;
    endfunction

    function automatic logic signed [MEAN_W-1:0] to_mm(input logic signed [C_W-1:0] c);
        logic signed [C_W-1:0] t;
        logic signed [MEAN_W-1:0] r;
        t = (c + C_W'(128)) >>> 8;
        if (t > MM_MAX) begin
            r = MEAN_W'(MM_MAX);
        end else if (t < -MM_MAX - C_W'(1)) begin
            r = MEAN_W'(-MM_MAX - C_W'(1));
        end else begin
            r = MEAN_W'(t);
        end
        return r;
    endfunction

    t_state                   r_state;
    t_pix                     r_item;
    logic signed [P_W-1:0]    r_px;
    logic signed [P_W-1:0]    r_py;
    logic signed [63:0]       r_prod;
    logic signed [63:0]       r_acc;
    logic signed [C_W-1:0]    r_c [3];
    logic [1:0]               r_row;
    logic [1:0]               r_col;
    logic signed [NW-1:0]     r_uc;
    logic signed [NW-1:0]     r_vc;
    logic signed [SUM_W-1:0]  r_sx;
    logic signed [SUM_W-1:0]  r_sy;
    logic signed [SUM_W-1:0]  r_sz;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [MEAN_W-1:0] r_mean [3];
    logic [1:0]               r_axis;
    logic                     r_out_valid;

    logic                     mul_en;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic                     div_start;
    logic signed [NW-1:0]     div_num;
    logic [DW-1:0]            div_den;
    logic                     div_done;
    logic signed [NW-1:0]     div_quot;

    logic signed [17:0]       dx_diff;
    logic signed [17:0]       dy_diff;
    logic signed [P_W-1:0]    zd;
    logic signed [P_W-1:0]    p_sel;
    logic signed [63:0]       acc_sum;
    logic signed [C_W-1:0]    c_new;
    logic [16:0]              u_ctr;
    logic [16:0]              v_ctr;
    logic [17:0]              x_lo;
    logic [17:0]              x_hi;
    logic [17:0]              y_lo;
    logic [17:0]              y_hi;
    logic                     in_roi;
    logic [1:0]               m_axis;
    logic signed [SUM_W-1:0]  m_sum;
    logic signed [NW-1:0]     m_off;
    t_state                   after_pix;
    logic                     out_load;

    assign dx_diff = $signed({2'b0, r_item.u, 4'b0}) - $signed({2'b0, i_cfg.cx_d});
    assign dy_diff = $signed({2'b0, r_item.v, 4'b0}) - $signed({2'b0, i_cfg.cy_d});
    assign zd      = P_W'({r_item.depth, 8'b0});
    assign acc_sum = r_acc + r_prod;
    assign c_new   = C_W'((acc_sum + 64'sd131072) >>> 18);

    always_comb begin
        case (r_col)
            2'd0:    p_sel = r_px;
            2'd1:    p_sel = r_py;
            default: p_sel = zd;
        endcase
    end

    assign u_ctr  = 17'(i_cfg.roi_x) + 17'(i_cfg.roi_w[15:1]);
    assign v_ctr  = 17'(i_cfg.roi_y) + 17'(i_cfg.roi_h[15:1]);
    assign x_lo   = 18'(u_ctr) - 18'(i_cfg.roi_w[15:2]);
    assign x_hi   = 18'(u_ctr) + 18'(i_cfg.roi_w[15:2]);
    assign y_lo   = 18'(v_ctr) - 18'(i_cfg.roi_h[15:2]);
    assign y_hi   = 18'(v_ctr) + 18'(i_cfg.roi_h[15:2]);
    assign in_roi = (r_uc >= $signed(NW'({x_lo, 4'b0}))) && (r_uc < $signed(NW'({x_hi, 4'b0})))
                 && (r_vc >= $signed(NW'({y_lo, 4'b0}))) && (r_vc < $signed(NW'({y_hi, 4'b0})));

    assign after_pix = r_item.last ? S_MEAN : S_IDLE;
    assign m_axis    = (r_state == S_MEAN) ? 2'd0 : r_axis + 2'd1;
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (m_axis)
            2'd0:    m_sum = r_sx;
            2'd1:    m_sum = r_sy;
            default: m_sum = r_sz;
        endcase
        case (r_axis)
            2'd0:    m_off = NW'(MEAN_OFF_X);
            2'd1:    m_off = '0;
            default: m_off = NW'(MEAN_OFF_Z);
        endcase
    end

    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_PX: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(dx_diff);
                mul_b  = MB_W'($signed({1'b0, r_item.depth}));
            end
            S_PY: begin
                mul_en    = 1'b1;
                mul_a     = MA_W'(dy_diff);
                mul_b     = MB_W'($signed({1'b0, r_item.depth}));
                div_start = 1'b1;
                div_num   = (NW'(r_prod) <<< 9) + $signed(NW'(i_cfg.fx_d));
                div_den   = DW'({i_cfg.fx_d, 1'b0});
            end
            S_DX: begin
                div_start = div_done;
                div_num   = (NW'(r_prod) <<< 9) + $signed(NW'(i_cfg.fy_d));
                div_den   = DW'({i_cfg.fy_d, 1'b0});
            end
            S_RMUL: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(field21(i_cfg.rot[r_row], r_col));
                mul_b  = MB_W'(p_sel);
            end
            S_PU: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(i_cfg.fx_c);
                mul_b  = MB_W'(r_c[0]);
            end
            S_PV: begin
                mul_en    = 1'b1;
                mul_a     = MA_W'(i_cfg.fy_c);
                mul_b     = MB_W'(r_c[1]);
                div_start = 1'b1;
                div_num   = NW'(r_prod);
                div_den   = DW'(r_c[2]);
            end
            S_DU: begin
                div_start = div_done;
                div_num   = NW'(r_prod);
                div_den   = DW'(r_c[2]);
            end
            S_MEAN: begin
                div_start = (r_cnt != '0);
                div_num   = (NW'(m_sum) <<< 1) + $signed(NW'(r_cnt));
                div_den   = DW'({r_cnt, 1'b0});
            end
            S_MDIV: begin
                div_start = div_done && (r_axis != 2'd2);
                div_num   = (NW'(m_sum) <<< 1) + $signed(NW'(r_cnt));
                div_den   = DW'({r_cnt, 1'b0});
            end
            default: ;
        endcase
    end

    drcp_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= 64'(mul_a * mul_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sz        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_axis      <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (i_q_item.keep && r_cnt < CNT_W'(HIT_MAX)) begin
                            r_state <= S_PX;
                        end else if (i_q_item.last) begin
                            r_state <= S_MEAN;
                        end
                    end
                end
                S_PX: r_state <= S_PY;
                S_PY: r_state <= S_DX;
                S_DX: begin
                    if (div_done) begin
                        r_px    <= sat_p(div_quot);
                        r_state <= S_DY;
                    end
                end
                S_DY: begin
                    if (div_done) begin
                        r_py    <= sat_p(div_quot);
                        r_row   <= 2'd0;
                        r_col   <= 2'd0;
                        r_acc   <= 64'(field21(i_cfg.trans, 2'd0)) <<< 26;
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: r_state <= S_RACC;
                S_RACC: begin
                    if (r_col == 2'd2) begin
                        r_c[r_row] <= c_new;
                        if (r_row == 2'd2) begin
                            r_state <= (c_new > 0) ? S_PU : after_pix;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_col   <= 2'd0;
                            r_acc   <= 64'(field21(i_cfg.trans, r_row + 2'd1)) <<< 26;
                            r_state <= S_RMUL;
                        end
                    end else begin
                        r_acc   <= acc_sum;
                        r_col   <= r_col + 2'd1;
                        r_state <= S_RMUL;
                    end
                end
                S_PU: r_state <= S_PV;
                S_PV: r_state <= S_DU;
                S_DU: begin
                    if (div_done) begin
                        r_uc    <= div_quot + $signed(NW'(i_cfg.cx_c));
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    if (div_done) begin
                        r_vc    <= div_quot + $signed(NW'(i_cfg.cy_c));
                        r_state <= S_ROI;
                    end
                end
                S_ROI: begin
                    if (in_roi) begin
                        r_sx  <= r_sx + SUM_W'(to_mm(r_c[0]));
                        r_sy  <= r_sy + SUM_W'(to_mm(r_c[1]));
                        r_sz  <= r_sz + SUM_W'(to_mm(r_c[2]));
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_state <= after_pix;
                end
                S_MEAN: begin
                    if (r_cnt == '0) begin
                        r_mean[0] <= '0;
                        r_mean[1] <= '0;
                        r_mean[2] <= '0;
                        r_state   <= S_OUT;
                    end else begin
                        r_axis  <= 2'd0;
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (div_done) begin
                        r_mean[r_axis] <= sat_m(div_quot + m_off);
                        if (r_axis == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sz    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_mean_x_mm   <= r_mean[0];
            o_mean_y_mm   <= r_mean[1];
            o_mean_z_mm   <= r_mean[2];
            o_point_count <= COUNT_W'(r_cnt);
            o_found       <= (r_cnt != '0);
        end
    end

    assign o_q_pop     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/depth_roi_centroid_projector.sv
`timescale 1ns / 1ps
// Top level of the depth ROI centroid projector.
// Depth pixel words are screened on entry and held in a 4-word queue; the back
// end then works through one queued pixel at a time. A pixel that is screened
// out is dropped by the idle state as it is popped; one whose colour-frame
// depth is not positive costs two divisions and the rotation products. A pixel
// that is projected costs four divisions on the shared one-bit-a-cycle divider
// (64 quotient bits each) and the rotation products on the single multiplier.
// The word carrying last_pixel adds three more divisions for the means, if any
// point was counted, before the result word appears; the result is held in an
// output register so that the back end can go on with the next pixel words
// while it waits to be taken.
// Configuration may only be written while the block is idle.
module depth_roi_centroid_projector import drcp_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [COORD_W-1:0]       i_column,
    input  logic [COORD_W-1:0]       i_row,
    input  logic [DEPTH_W-1:0]       i_depth_mm,
    input  logic                     i_last_pixel,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [MEAN_W-1:0] o_mean_x_mm,
    output logic signed [MEAN_W-1:0] o_mean_y_mm,
    output logic signed [MEAN_W-1:0] o_mean_z_mm,
    output logic [COUNT_W-1:0]       o_point_count,
    output logic                     o_found
);

    t_cfg cfg;
    logic q_valid;
    t_pix q_item;
    logic q_pop;

    drcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    drcp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_depth_mm   (i_depth_mm),
        .i_last_pixel (i_last_pixel),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    drcp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mean_x_mm   (o_mean_x_mm),
        .o_mean_y_mm   (o_mean_y_mm),
        .o_mean_z_mm   (o_mean_z_mm),
        .o_point_count (o_point_count),
        .o_found       (o_found)
    );

endmodule

// File: hw/rtl/drcp_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the depth ROI centroid projector, with its bind.
module drcp_chk import drcp_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [MEAN_W-1:0] o_mean_x_mm,
    input logic signed [MEAN_W-1:0] o_mean_y_mm,
    input logic signed [MEAN_W-1:0] o_mean_z_mm,
    input logic [COUNT_W-1:0]       o_point_count,
    input logic                     o_found
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_count)
            && $stable(o_mean_x_mm) && $stable(o_found))
        else $error("result word changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_mean_x_mm == '0 && o_mean_y_mm == '0
            && o_mean_z_mm == '0 && o_point_count == '0)
        else $error("empty frame result not zero");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_point_count != '0)
        else $error("found set with zero count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid straight after reset");

endmodule

bind depth_roi_centroid_projector drcp_chk u_drcp_chk (.*);

// File: tb/depth_roi_centroid_projector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the depth ROI centroid projector.
module depth_roi_centroid_projector_tb;
    import drcp_pkg::*;

    typedef struct {
        logic signed [MEAN_W-1:0] mx;
        logic signed [MEAN_W-1:0] my;
        logic signed [MEAN_W-1:0] mz;
        logic [COUNT_W-1:0]       cnt;
        logic                     found;
    } centroid_t;

    class centroid_board;
        logic [63:0] regs [8];
        longint      sx, sy, sz, hits;
        centroid_t   pending_q [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[REG_DLIMIT] = 64'(DLIMIT_RST);
            sx = 0; sy = 0; sz = 0; hits = 0; errors = 0;
        endfunction

        static function longint fdiv(longint n, longint d);
            if (n >= 0) return n / d;
            return -((-n + d - 1) / d);
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint f16(logic [63:0] w, int k);
            logic [63:0] t;
            t = w >> (16 * k);
            return longint'(t[15:0]);
        endfunction

        function longint f21(logic [63:0] w, int k);
            logic [63:0]        t;
            logic signed [20:0] f;
            t = w >> (21 * k);
            f = t[20:0];
            return longint'(f);
        endfunction

        function longint whole_mm(longint q8);
            return clip(fdiv(q8 + 128, 256), -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            if (idx == REG_DLIMIT) regs[idx] = {48'd0, val[15:0]};
            else if (idx inside {REG_ROT_X, REG_ROT_Y, REG_ROT_Z, REG_TRANS})
                regs[idx] = {1'b0, val[62:0]};
            else regs[idx] = val;
        endfunction

        function void project(longint u, longint v, longint d);
            longint lim, fxd, fyd, cxd, cyd, fxc, fyc, cxc, cyc;
            longint p [3];
            longint c [3];
            longint acc, uc, vc, uctr, vctr, rw, rh;
            lim = (64'sd1 <<< 39) - 1;
            fxd = f16(regs[0], 0); fyd = f16(regs[0], 1);
            cxd = f16(regs[0], 2); cyd = f16(regs[0], 3);
            fxc = f16(regs[1], 0); fyc = f16(regs[1], 1);
            cxc = f16(regs[1], 2); cyc = f16(regs[1], 3);
            if (d == 0 || d >= f16(regs[REG_DLIMIT], 0)) return;
            if (fxd == 0 || fyd == 0) return;
            if (u >= DEF_MAX_WIDTH || v >= DEF_MAX_HEIGHT) return;
            if (hits >= longint'(DEF_MAX_WIDTH) * DEF_MAX_HEIGHT) return;
            p[0] = clip(fdiv((u * 16 - cxd) * d * 512 + fxd, 2 * fxd), -lim, lim);
            p[1] = clip(fdiv((v * 16 - cyd) * d * 512 + fyd, 2 * fyd), -lim, lim);
            p[2] = d * 256;
            for (int r = 0; r < 3; r++) begin
                acc = f21(regs[2 + r], 0) * p[0] + f21(regs[2 + r], 1) * p[1]
                    + f21(regs[2 + r], 2) * p[2] + f21(regs[REG_TRANS], r) * (64'sd1 <<< 26);
                c[r] = fdiv(acc + (64'sd1 <<< 17), 64'sd1 <<< 18);
            end
            if (c[2] <= 0) return;
            uc = fdiv(fxc * c[0], c[2]) + cxc;
            vc = fdiv(fyc * c[1], c[2]) + cyc;
            rw = f16(regs[REG_ROI], 2);
            rh = f16(regs[REG_ROI], 3);
            uctr = f16(regs[REG_ROI], 0) + rw / 2;
            vctr = f16(regs[REG_ROI], 1) + rh / 2;
            if (uc < (uctr - rw / 4) * 16 || uc >= (uctr + rw / 4) * 16) return;
            if (vc < (vctr - rh / 4) * 16 || vc >= (vctr + rh / 4) * 16) return;
            sx += whole_mm(c[0]);
            sy += whole_mm(c[1]);
            sz += whole_mm(c[2]);
            hits++;
        endfunction

        function logic [MEAN_W-1:0] mean_of(longint s, longint off);
            longint m;
            m = fdiv(2 * s + hits, 2 * hits) + off;
            m = clip(m, -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1);
            return m[MEAN_W-1:0];
        endfunction

        function void note_pixel(int u, int v, int d, bit last);
            centroid_t e;
            project(u, v, d);
            if (!last) return;
            e = '{default: '0};
            if (hits > 0) begin
                e.mx = mean_of(sx, MEAN_OFF_X);
                e.my = mean_of(sy, 0);
                e.mz = mean_of(sz, MEAN_OFF_Z);
                e.cnt = hits[COUNT_W-1:0];
                e.found = 1'b1;
            end
            pending_q.push_back(e);
            sx = 0; sy = 0; sz = 0; hits = 0;
        endfunction

        function void check_result(centroid_t got);
            centroid_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word x=%0d y=%0d z=%0d n=%0d",
                         $time, got.mx, got.my, got.mz, got.cnt);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.mx !== e.mx) begin
                $display("%0t: mean_x exp %0d got %0d", $time, e.mx, got.mx); errors++;
            end
            if (got.my !== e.my) begin
                $display("%0t: mean_y exp %0d got %0d", $time, e.my, got.my); errors++;
            end
            if (got.mz !== e.mz) begin
                $display("%0t: mean_z exp %0d got %0d", $time, e.mz, got.mz); errors++;
            end
            if (got.cnt !== e.cnt) begin
                $display("%0t: count exp %0d got %0d", $time, e.cnt, got.cnt); errors++;
            end
            if (got.found !== e.found) begin
                $display("%0t: found exp %0b got %0b", $time, e.found, got.found); errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [COORD_W-1:0]       i_column = '0;
    logic [COORD_W-1:0]       i_row = '0;
    logic [DEPTH_W-1:0]       i_depth_mm = '0;
    logic                     i_last_pixel = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [MEAN_W-1:0] o_mean_x_mm, o_mean_y_mm, o_mean_z_mm;
    logic [COUNT_W-1:0]       o_point_count;
    logic                     o_found;

    centroid_board sb = new();
    bit            hold_req = 1'b0;
    int            lim_now = 20000;

    depth_roi_centroid_projector DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("** depth_roi_centroid_projector: FAILED **");
        $finish;
    end

    // result side
    initial begin
        centroid_t got;
        @(negedge i_clk);
        forever begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            got.mx = o_mean_x_mm; got.my = o_mean_y_mm; got.mz = o_mean_z_mm;
            got.cnt = o_point_count; got.found = o_found;
            sb.check_result(got);
            @(negedge i_clk);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        if (idx == REG_DLIMIT) lim_now = val[15:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(int u, int v, int d, bit last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_column     <= u[COORD_W-1:0];
        i_row        <= v[COORD_W-1:0];
        i_depth_mm   <= d[DEPTH_W-1:0];
        i_last_pixel <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(u, v, d, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
    endtask

    function automatic logic [62:0] pack21(int a, int b, int c);
        logic [31:0] ta, tb, tc;
        ta = a; tb = b; tc = c;
        return {tc[20:0], tb[20:0], ta[20:0]};
    endfunction

    function automatic logic [63:0] pack16(int a, int b, int c, int d);
        logic [31:0] ta, tb, tc, td;
        ta = a; tb = b; tc = c; td = d;
        return {td[15:0], tc[15:0], tb[15:0], ta[15:0]};
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic load_camera(int set);
        int q;
        q = 1 << 18;
        case (set)
            1: begin
                write_reg(REG_DEPTH_INTR, pack16(580*16, 580*16, 320*16, 240*16));
                write_reg(REG_COLOR_INTR, pack16(600*16, 600*16, 320*16, 240*16));
                write_reg(REG_ROT_X, pack21(q, 0, 0));
                write_reg(REG_ROT_Y, pack21(0, q, 0));
                write_reg(REG_ROT_Z, pack21(0, 0, q));
                write_reg(REG_TRANS, pack21(25, -10, 5));
                write_reg(REG_ROI, pack16(0, 0, 640, 480));
                write_reg(REG_DLIMIT, 64'd20000);
            end
            2: begin
                write_reg(REG_DEPTH_INTR, pack16($urandom_range(4000, 12000),
                          $urandom_range(4000, 12000), $urandom_range(4000, 6000),
                          $urandom_range(3000, 5000)));
                write_reg(REG_COLOR_INTR, pack16($urandom_range(4000, 12000),
                          $urandom_range(4000, 12000), $urandom_range(4000, 6000),
                          $urandom_range(3000, 5000)));
                write_reg(REG_ROT_X, pack21(q + jitter(8000), jitter(8000), jitter(8000)));
                write_reg(REG_ROT_Y, pack21(jitter(8000), q + jitter(8000), jitter(8000)));
                write_reg(REG_ROT_Z, pack21(jitter(8000), jitter(8000), q + jitter(8000)));
                write_reg(REG_TRANS, pack21(jitter(200), jitter(200), jitter(200)));
                write_reg(REG_ROI, pack16($urandom_range(0, 100), $urandom_range(0, 100),
                          $urandom_range(200, 700), $urandom_range(200, 500)));
                write_reg(REG_DLIMIT, 64'($urandom_range(3000, 65535)));
            end
            3: begin
                write_reg(REG_DEPTH_INTR, '1);
                write_reg(REG_COLOR_INTR, '1);
                write_reg(REG_ROT_X, '1);
                write_reg(REG_ROT_Y, '1);
                write_reg(REG_ROT_Z, '1);
                write_reg(REG_TRANS, '1);
                write_reg(REG_ROI, '1);
                write_reg(REG_DLIMIT, 64'hFFFF);
            end
            4: begin
                // colour depth pushed behind the camera, then a limit of one
                write_reg(REG_DEPTH_INTR, pack16(16, 16, 0, 0));
                write_reg(REG_COLOR_INTR, pack16(1, 1, 0, 0));
                write_reg(REG_ROT_X, pack21(-(1 << 20), (1 << 20) - 1, 0));
                write_reg(REG_ROT_Y, pack21(0, -(1 << 20), (1 << 20) - 1));
                write_reg(REG_ROT_Z, pack21(0, 0, q));
                write_reg(REG_TRANS, pack21((1 << 20) - 1, -(1 << 20), -(1 << 20)));
                write_reg(REG_ROI, '0);
                write_reg(REG_DLIMIT, 64'd1);
            end
            default: begin
                write_reg(REG_DEPTH_INTR, {$urandom, $urandom});
                write_reg(REG_COLOR_INTR, {$urandom, $urandom});
                write_reg(REG_ROT_X, {$urandom, $urandom});
                write_reg(REG_ROT_Y, {$urandom, $urandom});
                write_reg(REG_ROT_Z, pack21(jitter(1 << 19), jitter(1 << 19), q));
                write_reg(REG_TRANS, {$urandom, $urandom});
                write_reg(REG_ROI, {$urandom, $urandom});
                write_reg(REG_DLIMIT, 64'($urandom_range(1, 65535)));
            end
        endcase
    endtask

    task automatic random_frames(int budget);
        int sent, len, u, v, d;
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(1, 16);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) < 8) begin
                    u = $urandom_range(0, 639);
                    v = $urandom_range(0, 479);
                    d = $urandom_range(300, 8000);
                end else begin
                    u = $urandom_range(0, 4095);
                    v = $urandom_range(0, 4095);
                    case ($urandom_range(0, 3))
                        0: d = 0;
                        1: d = lim_now;
                        default: d = $urandom_range(0, 65535);
                    endcase
                end
                send_pixel(u, v, d, k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero focal length, nothing accumulates
        send_pixel(320, 240, 1000, 1'b0);
        send_pixel(4095, 4095, 65535, 1'b1);
        random_frames(30);
        drain();

        load_camera(1);
        send_pixel(0, 0, 0, 1'b1);
        send_pixel(320, 240, 1000, 1'b0);
        send_pixel(320, 240, 19999, 1'b0);
        send_pixel(320, 240, 20000, 1'b0);
        send_pixel(400, 300, 65535, 1'b0);
        send_pixel(0, 0, 1, 1'b0);
        send_pixel(4095, 0, 500, 1'b0);
        send_pixel(0, 4095, 500, 1'b0);
        send_pixel(4095, 4095, 500, 1'b0);
        send_pixel(250, 200, 2000, 1'b1);
        send_pixel(320, 240, 1, 1'b1);
        send_pixel(300, 250, 3000, 1'b0);
        send_pixel(340, 230, 3100, 1'b1);
        random_frames(330);
        drain();

        load_camera(2);
        hold_req = 1'b1;
        random_frames(330);
        drain();

        load_camera(3);
        send_pixel(4095, 4095, 65534, 1'b1);
        random_frames(150);
        drain();

        load_camera(4);
        random_frames(120);
        drain();

        load_camera(5);
        random_frames(200);
        drain();

        load_camera(2);
        random_frames(420);
        drain();

        if (sb.errors == 0)
            $display("** depth_roi_centroid_projector: PASSED **");
        else
            $display("** depth_roi_centroid_projector: FAILED **");
        $finish;
    end

endmodule
